>>> rtl/acsc_pkg.sv
// Shared types and constants for the core activity sample counter.
// Holds field widths, register and state codes, and the cell control bundle.
// No dependencies.
`default_nettype none

package acsc_pkg;

   // Field widths
   localparam int CNT_W   = 16;
   localparam int MASK_W  = 18;
   localparam int INDEX_W = 5;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Register index codes (word address bit paddr[2])
   localparam logic REG_SAMPLES_PER_RECORD = 1'b0;

   // Reset value of the record limit
   localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd1;

   // Sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   // Control bundle broadcast to every cell
   typedef struct packed {
      logic tick;   // sampling item accepted this cycle
      logic shift;  // move every count one cell toward the output
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/core_activity_sample_counter_top.sv
// Core activity sample counter: each accepted item is one sampling tick whose
// sleep mask bumps the counter of every active core. When the sample count
// reaches samples_per_record (0 acts as 1) the block emits NUM_CORES items,
// core 0 first, the last one flagged, and clears its window. A tick that does
// not close a record leaves req_ready high; a tick that closes one keeps
// req_ready low while the counts shift out of the cell chain, one cell per
// cycle while the consumer does not stall rsp_ready.
// Depends on acsc_pkg and acsc_cell.
`default_nettype none

module core_activity_sample_counter_top #(
   parameter int NUM_CORES = 18
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // sampling ticks
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [acsc_pkg::MASK_W-1:0]   req_sleep_mask,
   // per-core results
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [acsc_pkg::INDEX_W-1:0]  rsp_core_index,
   output      logic [acsc_pkg::CNT_W-1:0]    rsp_active_count,
   output      logic                          rsp_last_core,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [acsc_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [acsc_pkg::DATA_W-1:0]   pwdata,
   output      logic [acsc_pkg::DATA_W-1:0]   prdata,
   output      logic                          pready
);

   localparam int IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CORES - 1);

   // Register port
   logic [acsc_pkg::CNT_W-1:0] limit_ff;
   logic                       reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == acsc_pkg::REG_SAMPLES_PER_RECORD);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= acsc_pkg::LIMIT_RESET;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         limit_ff <= pwdata[acsc_pkg::CNT_W-1:0];
      end
   end

   assign prdata = reg_sel ? acsc_pkg::DATA_W'(limit_ff) : '0;

   // Sequencer state
   logic            state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [acsc_pkg::CNT_W-1:0] samples_ff, samples_in, samples_inc, limit_eff;
   logic            tick, record, load;
   acsc_pkg::cell_ctrl_type ctrl;

   assign req_ready = (state_ff == acsc_pkg::ST_IDLE);
   assign tick      = req_valid && req_ready;
   assign load      = (state_ff == acsc_pkg::ST_DUMP) && (!rsp_valid || rsp_ready);

   // Saturating sample count and record test
   assign samples_inc = (samples_ff != acsc_pkg::CNT_MAX) ?
                        samples_ff + acsc_pkg::CNT_W'(1) : samples_ff;
   assign limit_eff   = (limit_ff == '0) ? acsc_pkg::CNT_W'(1) : limit_ff;
   assign record      = tick && (samples_inc >= limit_eff);

   always_comb begin
      samples_in = samples_ff;
      if (tick) begin
         samples_in = record ? '0 : samples_inc;
      end
   end

   // Advance the dump index one core per loaded result
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         acsc_pkg::ST_IDLE: begin
            if (record) begin
               state_in = acsc_pkg::ST_DUMP;
               idx_in   = '0;
            end
         end
         acsc_pkg::ST_DUMP: begin
            if (load) begin
               if (idx_ff == IDX_LAST) begin
                  state_in = acsc_pkg::ST_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = acsc_pkg::ST_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= acsc_pkg::ST_IDLE;
         idx_ff     <= '0;
         samples_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         samples_ff <= samples_in;
      end
   end

   // Cell chain: cell 0 feeds the output, zeros enter at the far end
   logic [acsc_pkg::CNT_W-1:0] counts [NUM_CORES];

   assign ctrl.tick  = tick;
   assign ctrl.shift = load;

   for (genvar i = 0; i < NUM_CORES; i++) begin : g_cell
      logic                       asleep;
      logic [acsc_pkg::CNT_W-1:0] next_count;

      if (i < acsc_pkg::MASK_W) begin : g_mask
         assign asleep = req_sleep_mask[i];
      end else begin : g_nomask
         assign asleep = 1'b0;
      end

      if (i == NUM_CORES - 1) begin : g_tail
         assign next_count = '0;
      end else begin : g_link
         assign next_count = counts[i+1];
      end

      acsc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .asleep    (asleep),
         .shift_in  (next_count),
         .count_out (counts[i])
      );
   end

   // Output register: hold until taken, load the head cell on each step
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [acsc_pkg::INDEX_W-1:0] rsp_index_ff;
   logic [acsc_pkg::CNT_W-1:0]   rsp_count_ff;
   logic                         rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_index_ff <= acsc_pkg::INDEX_W'(idx_ff);
         rsp_count_ff <= counts[0];
         rsp_last_ff  <= (idx_ff == IDX_LAST);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_core_index   = rsp_index_ff;
   assign rsp_active_count = rsp_count_ff;
   assign rsp_last_core    = rsp_last_ff;

   // Checks
   a_no_tick_in_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acsc_pkg::ST_DUMP) |-> !req_ready)
      else $error("input ready during record dump");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_core) |->
         (rsp_core_index == acsc_pkg::INDEX_W'(NUM_CORES - 1)))
      else $error("last flag on wrong core");

   a_record_clears: assert property (@(posedge clock) disable iff (reset)
      record |=> (samples_ff == '0) && (state_ff == acsc_pkg::ST_DUMP))
      else $error("record did not clear sample count or start dump");

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acsc_pkg::ST_IDLE) |-> (idx_ff == '0))
      else $error("dump index not parked while idle");

   a_last_ends_dump: assert property (@(posedge clock) disable iff (reset)
      (load && (idx_ff == IDX_LAST)) |=> (state_ff == acsc_pkg::ST_IDLE))
      else $error("dump did not end after last core");

endmodule

`default_nettype wire

>>> rtl/acsc_cell.sv
// One counter cell of the activity chain: a saturating 16-bit counter that
// can also take its neighbor's count. Depends on acsc_pkg.
`default_nettype none

module acsc_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire acsc_pkg::cell_ctrl_type     ctrl,
   input  wire logic                        asleep,
   input  wire logic [acsc_pkg::CNT_W-1:0]  shift_in,
   output      logic [acsc_pkg::CNT_W-1:0]  count_out
);

   logic [acsc_pkg::CNT_W-1:0] count_ff;
   logic [acsc_pkg::CNT_W-1:0] count_in;

   // Take the neighbor's count on shift, else count active ticks, saturating
   always_comb begin
      count_in = count_ff;
      if (ctrl.shift) begin
         count_in = shift_in;
      end else if (ctrl.tick && !asleep && (count_ff != acsc_pkg::CNT_MAX)) begin
         count_in = count_ff + acsc_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_out = count_ff;

endmodule

`default_nettype wire
